// File: sv/rpa_pkg.sv
// ============================================================================
// rpa_pkg: shared types and constants for the RSSI proximity alert
// Window geometry, zone codes, register indexes and the zone lookup tables.
// ============================================================================
package rpa_pkg;

    // Averaging window and LED bar size.
    localparam int WINDOW  = 8;
    localparam int LED_MAX = 10;

    // Derived widths for the moving average. The magnitude of the most
    // negative sum needs every bit of the sum width.
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(128 * WINDOW) + 1;
    localparam int MAG_W  = SUM_W;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    // Fixed field widths.
    localparam int RSSI_W    = 8;
    localparam int ZONE_W    = 3;
    localparam int LED_W     = 4;
    localparam int BEEP_W    = 9;
    localparam int PER_W     = 10;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Transaction kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Zone codes.
    localparam logic [ZONE_W-1:0] ZONE_UNKNOWN    = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_VERY_CLOSE = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_CLOSE      = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_MEDIUM     = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_FAR        = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_EDGE       = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_VC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_F     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd6;

    // Request to the iterative divider.
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [FILL_W-1:0]       divisor;
    } div_req_t;

    // One result transaction.
    typedef struct packed {
        logic [ZONE_W-1:0]        zone;
        logic signed [RSSI_W-1:0] avg_rssi;
        logic                     led_on;
        logic [LED_W-1:0]         lit_count;
        logic                     beep_start;
        logic [BEEP_W-1:0]        beep_ms;
        logic                     buzz_halt;
    } rsp_t;

    function automatic logic [PER_W-1:0] blink_period(input logic [ZONE_W-1:0] z);
        logic [PER_W-1:0] p;
        unique case (z)
            ZONE_VERY_CLOSE: p = 10'd50;
            ZONE_CLOSE:      p = 10'd100;
            ZONE_MEDIUM:     p = 10'd200;
            ZONE_FAR:        p = 10'd400;
            ZONE_EDGE:       p = 10'd800;
            default:         p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [LED_W-1:0] zone_leds(input logic [ZONE_W-1:0] z);
        int n;
        unique case (z)
            ZONE_VERY_CLOSE: n = 10;
            ZONE_CLOSE:      n = 7;
            ZONE_MEDIUM:     n = 5;
            ZONE_FAR:        n = 3;
            ZONE_EDGE:       n = 1;
            default:         n = 0;
        endcase
        if (n > LED_MAX)
        begin
            n = LED_MAX;
        end
        return n[LED_W-1:0];
    endfunction

    function automatic logic [ZONE_W-1:0] classify(
        input logic signed [RSSI_W-1:0] a,
        input logic signed [RSSI_W-1:0] t_vc,
        input logic signed [RSSI_W-1:0] t_c,
        input logic signed [RSSI_W-1:0] t_m,
        input logic signed [RSSI_W-1:0] t_f
    );
        logic [ZONE_W-1:0] z;
        priority if (a >= t_vc) z = ZONE_VERY_CLOSE;
        else if (a >= t_c)      z = ZONE_CLOSE;
        else if (a >= t_m)      z = ZONE_MEDIUM;
        else if (a >= t_f)      z = ZONE_FAR;
        else                    z = ZONE_EDGE;
        return z;
    endfunction

endpackage

// File: sv/rpa_req_if.sv
// ============================================================================
// rpa_req_if: request channel
// Carries a sample or tick transaction with valid/ready handshake.
// ============================================================================
interface rpa_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic signed [7:0] rssi_sample;

    modport source (output valid, output req_type, output rssi_sample, input ready);
    modport sink   (input valid, input req_type, input rssi_sample, output ready);
endinterface

// File: sv/rpa_rsp_if.sv
// ============================================================================
// rpa_rsp_if: result channel
// Carries one result transaction with valid/ready handshake.
// ============================================================================
interface rpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  zone;
    logic signed [7:0] avg_rssi;
    logic        led_on;
    logic [3:0]  lit_count;
    logic        beep_start;
    logic [8:0]  beep_ms;
    logic        buzz_halt;

    modport source (output valid, output zone, output avg_rssi, output led_on,
                    output lit_count, output beep_start, output beep_ms,
                    output buzz_halt, input ready);
    modport sink   (input valid, input zone, input avg_rssi, input led_on,
                    input lit_count, input beep_start, input beep_ms,
                    input buzz_halt, output ready);
endinterface

// File: sv/rpa_divider.sv
// ============================================================================
// rpa_divider: iterative signed divider
// Restoring division of the window sum by the fill count, one quotient bit
// per cycle, truncating toward zero.
// ============================================================================
module rpa_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpa_pkg::div_req_t         req,
    output logic                      done,
    output logic signed [rpa_pkg::RSSI_W-1:0] quotient
);
    import rpa_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W:0]   rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [FILL_W-1:0] dsr_reg, dsr_next;
    logic              neg_reg, neg_next;

    logic [SUM_W-1:0]  abs_sum;
    logic [FILL_W:0]   shifted;
    logic [MAG_W-1:0]  signed_quo;

    always_comb
    begin
        abs_sum = req.dividend[SUM_W-1] ? (-req.dividend) : req.dividend;
        shifted = {rem_reg[FILL_W-1:0], quo_reg[MAG_W-1]};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            rem_next  = '0;
            quo_next  = abs_sum[MAG_W-1:0];
            dsr_next  = req.divisor;
            neg_next  = req.dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            // One restoring step: trial subtract and shift in the quotient bit.
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign signed_quo = neg_reg ? (-quo_reg) : quo_reg;
    assign quotient   = signed_quo[RSSI_W-1:0];
    assign done       = done_reg;

endmodule

// File: sv/rssi_proximity_alert.sv
// A tick's result goes through the pending register into the output register. A sample's
// result first waits on the divider, which gives one quotient bit a cycle.
// One transaction at a time: ready returns as the result is loaded into the output register,
// and stays low while the sink leaves the output register full.
// A finished result may wait in the output register while the next transaction is worked on.
// Reset is asynchronous and active low; it restores the register defaults and empties the window.
// ============================================================================
// rssi_proximity_alert: proximity zoning from a moving average of RSSI
// Samples feed a ring moving average that is sorted into zones by four
// thresholds; millisecond ticks drive the timeout, LED blinking and beeps.
// ============================================================================
module rssi_proximity_alert (
    input  logic                              clk,
    input  logic                              rst_n,
    rpa_req_if.sink                           req,
    rpa_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [rpa_pkg::CFG_W-1:0]         cfg_data
);
    import rpa_pkg::*;

    // The sequencer: idle, waiting on the divider, or holding a finished
    // result until the output register is free.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PEND
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic                     alert_en_reg, alert_en_next;
    logic                     buzzer_en_reg, buzzer_en_next;
    logic signed [RSSI_W-1:0] thr_vc_reg, thr_vc_next;
    logic signed [RSSI_W-1:0] thr_c_reg, thr_c_next;
    logic signed [RSSI_W-1:0] thr_m_reg, thr_m_next;
    logic signed [RSSI_W-1:0] thr_f_reg, thr_f_next;
    logic [TIME_W-1:0]        timeout_reg, timeout_next;

    // Moving average and alert state.
    logic signed [RSSI_W-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0]         ring_idx_reg, ring_idx_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [RSSI_W-1:0] avg_reg, avg_next;
    logic [ZONE_W-1:0]        zone_reg, zone_next;
    logic [TIME_W-1:0]        since_sample_reg, since_sample_next;
    logic [TIME_W-1:0]        since_toggle_reg, since_toggle_next;
    logic                     led_reg, led_next;

    // Result holding and output registers.
    rsp_t                     pend_reg, pend_next;
    rsp_t                     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    // Divider handshake.
    div_req_t                 div_req;
    logic                     div_done;
    logic signed [RSSI_W-1:0] div_quo;

    logic                     ring_we;
    logic                     req_fire;
    logic                     full;
    logic signed [RSSI_W-1:0] old_sample;
    logic [ZONE_W-1:0]        new_zone;
    logic [TIME_W-1:0]        ss_inc;
    logic [TIME_W-1:0]        st_inc;
    logic [PER_W-1:0]         period;

    rpa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        alert_en_next     = alert_en_reg;
        buzzer_en_next    = buzzer_en_reg;
        thr_vc_next       = thr_vc_reg;
        thr_c_next        = thr_c_reg;
        thr_m_next        = thr_m_reg;
        thr_f_next        = thr_f_reg;
        timeout_next      = timeout_reg;
        ring_idx_next     = ring_idx_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        avg_next          = avg_reg;
        zone_next         = zone_reg;
        since_sample_next = since_sample_reg;
        since_toggle_next = since_toggle_reg;
        led_next          = led_reg;
        pend_next         = pend_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        div_req           = '0;
        ring_we           = 1'b0;

        full       = (fill_reg == FILL_W'(WINDOW));
        old_sample = ring_reg[ring_idx_reg];
        new_zone   = classify(div_quo, thr_vc_reg, thr_c_reg, thr_m_reg, thr_f_reg);
        ss_inc     = (since_sample_reg == '1) ? since_sample_reg : since_sample_reg + 1'b1;
        st_inc     = (since_toggle_reg == '1) ? since_toggle_reg : since_toggle_reg + 1'b1;
        period     = blink_period(zone_reg);

        // Configuration writes; indexes beyond the list are ignored.
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ALERT_EN:  alert_en_next  = cfg_data[0];
                CFG_BUZZER_EN: buzzer_en_next = cfg_data[0];
                CFG_THR_VC:    thr_vc_next    = cfg_data[RSSI_W-1:0];
                CFG_THR_C:     thr_c_next     = cfg_data[RSSI_W-1:0];
                CFG_THR_M:     thr_m_next     = cfg_data[RSSI_W-1:0];
                CFG_THR_F:     thr_f_next     = cfg_data[RSSI_W-1:0];
                CFG_TIMEOUT:   timeout_next   = cfg_data[TIME_W-1:0];
                default:       ;
            endcase
        end

        // The output register drains whenever the sink takes the result.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_SAMPLE)
                    begin
                        // Once the window is full the oldest sample drops out
                        // of the sum as the new one replaces it in the ring.
                        ring_we  = 1'b1;
                        sum_next = sum_reg + SUM_W'(req.rssi_sample)
                                   - (full ? SUM_W'(old_sample) : SUM_W'(0));
                        if (!full)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        ring_idx_next = (ring_idx_reg == IDX_W'(WINDOW - 1))
                                        ? '0 : ring_idx_reg + 1'b1;
                        since_sample_next = '0;
                        div_req.start     = 1'b1;
                        div_req.dividend  = sum_next;
                        div_req.divisor   = fill_next;
                        state_next        = S_DIV;
                    end
                    else
                    begin
                        // Tick: the counters always advance; alerts only act when enabled.
                        since_sample_next    = ss_inc;
                        since_toggle_next    = st_inc;
                        pend_next.beep_start = 1'b0;
                        pend_next.beep_ms    = '0;
                        pend_next.buzz_halt  = 1'b0;
                        if (alert_en_reg)
                        begin
                            if (ss_inc > timeout_reg)
                            begin
                                // Entering unknown stops the buzzer, once only.
                                if (zone_reg != ZONE_UNKNOWN)
                                begin
                                    zone_next           = ZONE_UNKNOWN;
                                    pend_next.buzz_halt = 1'b1;
                                end
                            end
                            else if ((zone_leds(zone_reg) != '0) && (period != '0)
                                     && (st_inc >= TIME_W'(period)))
                            begin
                                led_next          = !led_reg;
                                since_toggle_next = '0;
                                if (!led_reg && buzzer_en_reg)
                                begin
                                    pend_next.beep_start = 1'b1;
                                    pend_next.beep_ms    = period[PER_W-1:1];
                                end
                            end
                        end
                        pend_next.zone      = zone_next;
                        pend_next.avg_rssi  = avg_reg;
                        pend_next.led_on    = led_next;
                        pend_next.lit_count = zone_leds(zone_next);
                        state_next          = S_PEND;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next             = div_quo;
                    zone_next            = new_zone;
                    pend_next.zone       = new_zone;
                    pend_next.avg_rssi   = div_quo;
                    pend_next.led_on     = led_reg;
                    pend_next.lit_count  = zone_leds(new_zone);
                    pend_next.beep_start = 1'b0;
                    pend_next.beep_ms    = '0;
                    pend_next.buzz_halt  = 1'b0;
                    state_next           = S_PEND;
                end
            end

            S_PEND:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            alert_en_reg     <= 1'b0;
            buzzer_en_reg    <= 1'b1;
            thr_vc_reg       <= -8'sd50;
            thr_c_reg        <= -8'sd60;
            thr_m_reg        <= -8'sd70;
            thr_f_reg        <= -8'sd80;
            timeout_reg      <= 16'd5000;
            ring_idx_reg     <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            avg_reg          <= '0;
            zone_reg         <= ZONE_UNKNOWN;
            since_sample_reg <= '0;
            since_toggle_reg <= '0;
            led_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            alert_en_reg     <= alert_en_next;
            buzzer_en_reg    <= buzzer_en_next;
            thr_vc_reg       <= thr_vc_next;
            thr_c_reg        <= thr_c_next;
            thr_m_reg        <= thr_m_next;
            thr_f_reg        <= thr_f_next;
            timeout_reg      <= timeout_next;
            ring_idx_reg     <= ring_idx_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            avg_reg          <= avg_next;
            zone_reg         <= zone_next;
            since_sample_reg <= since_sample_next;
            since_toggle_reg <= since_toggle_next;
            led_reg          <= led_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers carry no reset; ring entries are read only once written.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (ring_we)
        begin
            ring_reg[ring_idx_reg] <= req.rssi_sample;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.zone       = out_reg.zone;
    assign rsp.avg_rssi   = out_reg.avg_rssi;
    assign rsp.led_on     = out_reg.led_on;
    assign rsp.lit_count  = out_reg.lit_count;
    assign rsp.beep_start = out_reg.beep_start;
    assign rsp.beep_ms    = out_reg.beep_ms;
    assign rsp.buzz_halt  = out_reg.buzz_halt;

endmodule

// File: sv/rpa_checker.sv
// ============================================================================
// rpa_checker: port-level assertions for the RSSI proximity alert
// Watches the handshakes and the consistency of result transactions.
// ============================================================================
module rpa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] zone,
    input logic       led_on,
    input logic [3:0] lit_count,
    input logic       beep_start,
    input logic [8:0] beep_ms,
    input logic       buzz_halt
);
    import rpa_pkg::*;

    // A result that has not been taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // After every accepted transaction the block is busy, so ready is low in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready high straight after an accepted transaction");

    // A beep only starts when the LED turns on, and carries a length only then.
    a_beep_led: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && beep_start |-> led_on && (beep_ms != 9'd0))
        else $error("beep started without the LED turning on");

    a_beep_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !beep_start |-> (beep_ms == 9'd0))
        else $error("beep length without a beep");

    // A buzzer stop leaves the zone unknown with the bar dark.
    a_stop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && buzz_halt |-> (zone == ZONE_UNKNOWN) && (lit_count == 4'd0)
        && !beep_start)
        else $error("buzzer stop without entering the unknown zone");

endmodule

bind rssi_proximity_alert rpa_checker u_rpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .zone       (rsp.zone),
    .led_on     (rsp.led_on),
    .lit_count  (rsp.lit_count),
    .beep_start (rsp.beep_start),
    .beep_ms    (rsp.beep_ms),
    .buzz_halt  (rsp.buzz_halt)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the RSSI proximity alert
// Drives sample and tick transactions with random gaps and back-pressure,
// predicts every result with an independent model of the moving average,
// zoning, timeout and blink logic, and compares each result field by field.
// ============================================================================
module testbench;

    import rpa_pkg::*;

    // ------------------------------------------------------------------------
    // Run parameters.
    // ------------------------------------------------------------------------
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 10;
    // This comfortably covers the slowest transaction still in flight once
    // the queue is empty.
    localparam int SETTLE_CYCLES    = 20;
    // The limit is several times the slowest correct run with every stall
    // taken into account.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASE_ITEMS      = 165;
    localparam int PRESSURE_ITEMS   = 48;
    localparam int PRESSURE_HOLD    = 400;
    localparam int IDLE_PCT         = 30;

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test.
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    rpa_req_if req_ch ();
    rpa_rsp_if rsp_ch ();

    rssi_proximity_alert i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow of the configuration registers, updated as each write lands.
    // ------------------------------------------------------------------------
    logic              alert_on;
    logic              buzzer_on;
    logic signed [7:0] thr_vc;
    logic signed [7:0] thr_c;
    logic signed [7:0] thr_m;
    logic signed [7:0] thr_f;
    logic [15:0]       silence_limit;

    // ------------------------------------------------------------------------
    // Predicted state of the proximity logic.
    // ------------------------------------------------------------------------
    logic signed [7:0] ring_q [WINDOW];
    int                ring_pos;
    int                fill_n;
    int                window_total;
    logic signed [7:0] avg_q;
    logic [ZONE_W-1:0] zone_q;
    int                quiet_ticks;
    int                toggle_ticks;
    logic              led_q;

    // Results still owed by the block, oldest first.
    rsp_t expected_rsp_q [$];

    // ------------------------------------------------------------------------
    // Bookkeeping and handshake control.
    // ------------------------------------------------------------------------
    int   error_count  = 0;
    int   sent_count;
    int   result_count = 0;
    int   cycle_count  = 0;
    int   tx_idle_pct;
    int   rx_idle_pct;
    // The test toggles hold_trig to ask the receiver for a hold-off of
    // hold_len cycles; the receiver process does its own counting.
    int   hold_len;
    logic hold_trig;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    // ------------------------------------------------------------------------
    // Model helpers.
    // ------------------------------------------------------------------------
    function automatic logic [ZONE_W-1:0] zone_for(input logic signed [7:0] a);
        if (a >= thr_vc)
        begin
            return ZONE_VERY_CLOSE;
        end
        if (a >= thr_c)
        begin
            return ZONE_CLOSE;
        end
        if (a >= thr_m)
        begin
            return ZONE_MEDIUM;
        end
        if (a >= thr_f)
        begin
            return ZONE_FAR;
        end
        return ZONE_EDGE;
    endfunction

    // Blink half-period in ticks for each zone; the unknown zone never blinks.
    function automatic int blink_ms(input logic [ZONE_W-1:0] z);
        case (z)
            ZONE_VERY_CLOSE: return 50;
            ZONE_CLOSE:      return 100;
            ZONE_MEDIUM:     return 200;
            ZONE_FAR:        return 400;
            ZONE_EDGE:       return 800;
            default:         return 0;
        endcase
    endfunction

    function automatic int lit_leds(input logic [ZONE_W-1:0] z);
        int n;
        case (z)
            ZONE_VERY_CLOSE: n = 10;
            ZONE_CLOSE:      n = 7;
            ZONE_MEDIUM:     n = 5;
            ZONE_FAR:        n = 3;
            ZONE_EDGE:       n = 1;
            default:         n = 0;
        endcase
        return (n > LED_MAX) ? LED_MAX : n;
    endfunction

    task automatic reset_model();
        alert_on      = 1'b0;
        buzzer_on     = 1'b1;
        thr_vc        = -8'sd50;
        thr_c         = -8'sd60;
        thr_m         = -8'sd70;
        thr_f         = -8'sd80;
        silence_limit = 16'd5000;
        for (int i = 0; i < WINDOW; i++)
        begin
            ring_q[i] = '0;
        end
        ring_pos     = 0;
        fill_n       = 0;
        window_total = 0;
        avg_q        = '0;
        zone_q       = ZONE_UNKNOWN;
        quiet_ticks  = 0;
        toggle_ticks = 0;
        led_q        = 1'b0;
    endtask

    // Work out the result of one accepted transaction and queue it.
    task automatic predict_response(input logic kind, input logic signed [7:0] s);
        rsp_t want;
        int   per;
        want = '0;
        if (kind == REQ_SAMPLE)
        begin
            // The oldest entry leaves the sum only once the window is full.
            if (fill_n >= WINDOW)
            begin
                window_total -= ring_q[ring_pos];
            end
            else
            begin
                fill_n++;
            end
            ring_q[ring_pos] = s;
            window_total    += s;
            ring_pos         = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
            // Integer division truncates toward zero, as the block must.
            avg_q       = 8'(window_total / fill_n);
            zone_q      = zone_for(avg_q);
            quiet_ticks = 0;
        end
        else
        begin
            // Both counters run on every tick and stick at their maximum.
            if (quiet_ticks < 65535)
            begin
                quiet_ticks++;
            end
            if (toggle_ticks < 65535)
            begin
                toggle_ticks++;
            end
            if (alert_on)
            begin
                if (quiet_ticks > int'(silence_limit))
                begin
                    // Only the first tick past the timeout stops the buzzer;
                    // the LED phase is left as it was.
                    if (zone_q != ZONE_UNKNOWN)
                    begin
                        zone_q         = ZONE_UNKNOWN;
                        want.buzz_halt = 1'b1;
                    end
                end
                else
                begin
                    per = blink_ms(zone_q);
                    if (lit_leds(zone_q) != 0 && per != 0 && toggle_ticks >= per)
                    begin
                        led_q        = ~led_q;
                        toggle_ticks = 0;
                        if (led_q && buzzer_on)
                        begin
                            want.beep_start = 1'b1;
                            want.beep_ms    = BEEP_W'(per / 2);
                        end
                    end
                end
            end
        end
        want.zone      = zone_q;
        want.avg_rssi  = avg_q;
        want.led_on    = led_q;
        want.lit_count = LED_W'(lit_leds(zone_q));
        expected_rsp_q.push_back(want);
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes. These are only issued while the block is idle.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        // The write has landed at this edge; mirror it in the shadow copy.
        case (idx)
            CFG_ALERT_EN:  alert_on      = data[0];
            CFG_BUZZER_EN: buzzer_on     = data[0];
            CFG_THR_VC:    thr_vc        = data[7:0];
            CFG_THR_C:     thr_c         = data[7:0];
            CFG_THR_M:     thr_m         = data[7:0];
            CFG_THR_F:     thr_f         = data[7:0];
            CFG_TIMEOUT:   silence_limit = data[15:0];
            default:       ;
        endcase
    endtask

    task automatic apply_config(input logic alert, input logic buzzer,
                                input int t_vc, input int t_c, input int t_m,
                                input int t_f, input int limit_ms);
        write_reg(CFG_ALERT_EN,  CFG_W'(alert));
        write_reg(CFG_BUZZER_EN, CFG_W'(buzzer));
        write_reg(CFG_THR_VC,    CFG_W'(t_vc));
        write_reg(CFG_THR_C,     CFG_W'(t_c));
        write_reg(CFG_THR_M,     CFG_W'(t_m));
        write_reg(CFG_THR_F,     CFG_W'(t_f));
        write_reg(CFG_TIMEOUT,   CFG_W'(limit_ms));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Request side: offer one transaction and wait for it to be taken.
    // Returns just after the accepting edge with valid still high, so that a
    // back-to-back transaction keeps valid asserted without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic signed [7:0] s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.rssi_sample <= s;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sent_count++;
        predict_response(kind, s);
    endtask

    // Stop offering, wait for every owed result, then let the block settle.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A sample scattered a little around a level, kept inside the 8-bit range.
    function automatic logic signed [7:0] near_level(input int level);
        int v;
        v = level + int'($urandom_range(16)) - 8;
        if (v > 127)
        begin
            v = 127;
        end
        if (v < -128)
        begin
            v = -128;
        end
        return 8'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the receiver idles at random, and honours hold-off
    // requests by counting the cycles itself.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_trig != hold_seen)
        begin
            hold_seen     = hold_trig;
            hold_left     = hold_len - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result();
        rsp_t want;
        result_count++;
        if (expected_rsp_q.size() == 0)
        begin
            $display("%0t: result transaction with nothing expected, zone %0d avg %0d",
                     $time, rsp_ch.zone, rsp_ch.avg_rssi);
            error_count++;
        end
        else
        begin
            want = expected_rsp_q.pop_front();
            check_field("zone",       want.zone,       rsp_ch.zone);
            check_field("avg_rssi",   want.avg_rssi,   rsp_ch.avg_rssi);
            check_field("led_on",     want.led_on,     rsp_ch.led_on);
            check_field("lit_count",  want.lit_count,  rsp_ch.lit_count);
            check_field("beep_start", want.beep_start, rsp_ch.beep_start);
            check_field("beep_ms",    want.beep_ms,    rsp_ch.beep_ms);
            check_field("buzz_halt",  want.buzz_halt,  rsp_ch.buzz_halt);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            check_result();
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_rsp_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Straight out of reset with alerts off, a tick must show the unknown
    // zone, a zero average and a dark LED bar.
    task automatic test_reset_state();
        send_item(REQ_TICK, 8'sd0);
        wait_idle();
    endtask

    // Fill the window from empty with the extreme samples, check that the
    // average truncates toward zero, then wrap the ring so the oldest
    // entries are dropped from the sum.
    task automatic test_window_average();
        apply_config(1'b0, 1'b1, -50, -60, -70, -80, 5000);
        send_item(REQ_SAMPLE, 8'sd127);
        send_item(REQ_SAMPLE, -8'sd128);
        send_item(REQ_SAMPLE, -8'sd128);
        send_item(REQ_SAMPLE, -8'sd1);
        send_item(REQ_SAMPLE, 8'sd0);
        send_item(REQ_SAMPLE, 8'sd64);
        send_item(REQ_SAMPLE, -8'sd64);
        send_item(REQ_SAMPLE, 8'sd1);
        send_item(REQ_SAMPLE, 8'sd127);
        send_item(REQ_SAMPLE, -8'sd128);
        wait_idle();
    endtask

    // Thresholds at both ends of their range, then a spread that puts
    // the average into the middle zones.
    task automatic test_zone_thresholds();
        apply_config(1'b0, 1'b1, -128, -128, -128, -128, 5000);
        send_item(REQ_SAMPLE, -8'sd128);
        wait_idle();
        apply_config(1'b0, 1'b1, 127, 127, 127, 127, 5000);
        send_item(REQ_SAMPLE, 8'sd0);
        wait_idle();
        apply_config(1'b0, 1'b1, 0, -20, -40, -60, 5000);
        send_item(REQ_SAMPLE, -8'sd30);
        send_item(REQ_SAMPLE, -8'sd90);
        send_item(REQ_SAMPLE, 8'sd100);
        wait_idle();
    endtask

    // A zero timeout makes the first tick after a sample drop to the
    // unknown zone with a single buzzer stop; a second tick while already
    // unknown must do nothing. With the longest timeout an unknown zone
    // then sits still, and a fresh sample carries no pulses.
    task automatic test_timeout();
        apply_config(1'b1, 1'b1, -50, -60, -70, -80, 0);
        send_item(REQ_SAMPLE, -8'sd55);
        send_item(REQ_TICK, 8'sd0);
        send_item(REQ_TICK, -8'sd1);
        wait_idle();
        apply_config(1'b1, 1'b1, -50, -60, -70, -80, 65535);
        send_item(REQ_TICK, 8'sd0);
        send_item(REQ_SAMPLE, -8'sd45);
        send_item(REQ_TICK, 8'sd0);
        wait_idle();
    endtask

    // One phase of random traffic. Most of it is well formed: a short burst
    // of samples around a level followed by a run of ticks. The rest is
    // single transactions of any kind.
    task automatic run_phase(input int n_items);
        int sent;
        int level;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                level = int'($urandom_range(255)) - 128;
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++)
                begin
                    send_item(REQ_SAMPLE, near_level(level));
                end
                sent += burst;
                burst = $urandom_range(2, 80);
                for (int k = 0; k < burst; k++)
                begin
                    // The payload of a tick is ignored, so it is left random.
                    send_item(REQ_TICK, 8'($urandom));
                end
                sent += burst;
            end
            else
            begin
                send_item(($urandom_range(1) == 1) ? REQ_TICK : REQ_SAMPLE, 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int thr [4];

        // Default thresholds with a moderate timeout, both sides idling.
        apply_config(1'b1, 1'b1, -50, -60, -70, -80, 100);
        run_phase(PHASE_ITEMS);
        wait_idle();

        // Random but ordered thresholds, beeps muted, timeout never reached,
        // and a long stretch without any idling on either side.
        thr[0] = int'($urandom_range(255)) - 128;
        for (int i = 1; i < 4; i++)
        begin
            thr[i] = thr[i-1] - int'($urandom_range(40));
            if (thr[i] < -128)
            begin
                thr[i] = -128;
            end
        end
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(1'b1, 1'b0, thr[0], thr[1], thr[2], thr[3], 65535);
        run_phase(PHASE_ITEMS);
        wait_idle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        // Alerts off: ticks only advance the counters.
        apply_config(1'b0, 1'b0, -128, -128, -128, -128, 0);
        run_phase(PHASE_ITEMS);
        wait_idle();

        // Zero timeout: every tick after a sample falls straight to unknown.
        apply_config(1'b1, 1'b1, 127, 127, 127, 127, 0);
        run_phase(PHASE_ITEMS);
        wait_idle();

        // Unordered random thresholds and a random short timeout.
        for (int i = 0; i < 4; i++)
        begin
            thr[i] = int'($urandom_range(255)) - 128;
        end
        apply_config(1'b1, 1'b1, thr[0], thr[1], thr[2], thr[3], $urandom_range(20, 300));
        run_phase(PHASE_ITEMS);
        wait_idle();

        // Wide spread of thresholds across the whole range.
        apply_config(1'b1, 1'b1, 127, 0, -64, -128, 400);
        run_phase(PHASE_ITEMS);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering transactions back to back, so the block fills and stalls.
    task automatic test_backpressure();
        apply_config(1'b1, 1'b1, -50, -60, -70, -80, 30);
        tx_idle_pct = 0;
        hold_len    = PRESSURE_HOLD;
        hold_trig   = ~hold_trig;
        for (int k = 0; k < PRESSURE_ITEMS; k++)
        begin
            send_item((k % 3 == 0) ? REQ_SAMPLE : REQ_TICK, 8'($urandom));
        end
        wait_idle();
        tx_idle_pct = IDLE_PCT;
    endtask

    // A window full of the weakest sample gives the most negative sum the
    // block can hold; its average must come out as the weakest value and
    // sort into the edge zone, and ticks after it must keep that zone.
    task automatic test_weakest_window();
        apply_config(1'b1, 1'b1, -50, -60, -70, -80, 5000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int k = 0; k < WINDOW + 2; k++)
        begin
            send_item(REQ_SAMPLE, -8'sd128);
        end
        for (int k = 0; k < 3; k++)
        begin
            send_item(REQ_TICK, 8'sd0);
        end
        wait_idle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_SAMPLE;
        req_ch.rssi_sample = '0;
        sent_count         = 0;
        tx_idle_pct        = IDLE_PCT;
        rx_idle_pct        = IDLE_PCT;
        hold_len           = 0;
        hold_trig          = 1'b0;
        reset_model();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_window_average();
        test_zone_thresholds();
        test_timeout();
        test_random_traffic();
        test_backpressure();
        test_weakest_window();
        wait_idle();

        $display("Sent %0d transactions and checked %0d results in %0d cycles.",
                 sent_count, result_count, cycle_count);
        $display("Covered window fill and wrap, every zone, timeouts, blinking and beeps,");
        $display("a long receiver hold-off and a window full of the weakest sample.");
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d mismatches found.", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rpa_pkg.sv
sv/rpa_req_if.sv
sv/rpa_rsp_if.sv
sv/rpa_divider.sv
sv/rssi_proximity_alert.sv
sv/rpa_checker.sv
tb/testbench.sv
